// ===== rtl/swnp_pkg.sv =====
// ----------------------------------------------------------------------------
// swnp_pkg: shared types and constants for the skin weight normalizer
// Word layouts of both channels, float32 constants, the divider lane stage
// record and the truncating float32 to half conversion.
// ----------------------------------------------------------------------------
package swnp_pkg;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;
	localparam logic [31:0] QUIET_BIT    = 32'h00400000;
	localparam logic [31:0] POS_INF      = 32'h7F800000;
	localparam logic [31:0] ONE_F        = 32'h3F800000;
	localparam logic [7:0]  EXP_MAX      = 8'hFF;
	localparam logic [14:0] HALF_INF     = 15'h7C00;
	localparam int          F_BIAS       = 127;
	localparam int          H_BIAS       = 15;
	localparam int          QUO_BITS     = 25;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] weight_0;
		logic [31:0] weight_1;
		logic [31:0] weight_2;
		logic [31:0] weight_3;
		logic [31:0] bone_ids_in;
	} swnp_in_t;

	typedef struct packed {
		logic [31:0] out_pos_x;
		logic [31:0] out_pos_y;
		logic [31:0] out_pos_z;
		logic [63:0] half_weights;
		logic [31:0] bone_ids_out;
		logic [31:0] norm_weight_0;
		logic [31:0] norm_weight_1;
		logic [31:0] norm_weight_2;
		logic [31:0] norm_weight_3;
	} swnp_out_t;

	typedef struct packed {
		logic [QUO_BITS-1:0] rem;
		logic [QUO_BITS-1:0] quo;
		logic [23:0]         dsr;
		logic signed [9:0]   ex;
		logic                sg;
		logic                spec;
		logic [31:0]         sval;
	} swnp_div_t;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic [15:0] half_trunc(input logic [31:0] x);
		int e;
		e = int'(x[30:23]) - F_BIAS + H_BIAS;
		if (e <= 0) begin
			return {x[31], 15'd0};
		end else if (e >= 31) begin
			return {x[31], HALF_INF};
		end else begin
			return {x[31], 5'(e), x[22:13]};
		end
	endfunction

endpackage

// ===== rtl/swnp_if.sv =====
// ----------------------------------------------------------------------------
// swnp_if: valid/ready channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
interface swnp_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/swnp_fadd.sv =====
// ----------------------------------------------------------------------------
// swnp_fadd: three-stage float32 adder
// Align, add with leading-zero count, then normalize and round to nearest
// even. Subnormals, infinities and NaNs follow IEEE single precision.
// ----------------------------------------------------------------------------
module swnp_fadd (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import swnp_pkg::*;

	logic        spec_s1, sign_s1, zsg_s1, sub_s1;
	logic [31:0] sval_s1;
	logic [7:0]  e_s1;
	logic [26:0] mb_s1, al_s1;

	logic        spec_s2, sign_s2, zsg_s2;
	logic [31:0] sval_s2;
	logic [7:0]  e_s2;
	logic [27:0] r_s2;
	logic [4:0]  lz_s2;

	logic [31:0] y_s3;

	logic        a_nan, b_nan, a_inf, b_inf, swap, stk;
	logic [31:0] big, sml, sval;
	logic [7:0]  eb, es, d;
	logic [23:0] mb, ms;
	logic [26:0] msx, al;

	always_comb begin
		a_nan = is_nan(a);
		b_nan = is_nan(b);
		a_inf = is_inf(a);
		b_inf = is_inf(b);
		swap  = b[30:0] > a[30:0];
		big   = swap ? b : a;
		sml   = swap ? a : b;
		eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb    = {big[30:23] != 8'd0, big[22:0]};
		ms    = {sml[30:23] != 8'd0, sml[22:0]};
		d     = eb - es;
		msx   = {ms, 3'b000};
		if (d >= 8'd27) begin
			al  = '0;
			stk = |ms;
		end else begin
			al  = msx >> d;
			stk = |(msx & ~({27{1'b1}} << d));
		end
		al[0] = al[0] | stk;
		if (a_nan) begin
			sval = a | QUIET_BIT;
		end else if (b_nan) begin
			sval = b | QUIET_BIT;
		end else if (a_inf && b_inf && (a[31] != b[31])) begin
			sval = QNAN_DEFAULT;
		end else if (a_inf) begin
			sval = a;
		end else begin
			sval = b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= a_nan | b_nan | a_inf | b_inf;
			sval_s1 <= sval;
			sign_s1 <= big[31];
			zsg_s1  <= a[31] & b[31];
			sub_s1  <= a[31] ^ b[31];
			e_s1    <= eb;
			mb_s1   <= {mb, 3'b000};
			al_s1   <= al;
		end
	end

	logic [27:0] r;
	logic [4:0]  lz;

	always_comb begin
		if (sub_s1) begin
			r = {1'b0, mb_s1} - {1'b0, al_s1};
		end else begin
			r = {1'b0, mb_s1} + {1'b0, al_s1};
		end
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (r[i]) begin
				lz = 5'(26 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2 <= spec_s1;
			sval_s2 <= sval_s1;
			sign_s2 <= sign_s1;
			zsg_s2  <= zsg_s1;
			e_s2    <= e_s1;
			r_s2    <= r;
			lz_s2   <= lz;
		end
	end

	logic [7:0]  sh, en_e;
	logic [8:0]  e9;
	logic [26:0] m;
	logic        rnd;
	logic [31:0] p, res;

	always_comb begin
		sh   = 8'd0;
		en_e = e_s2 - 8'd1;
		if (r_s2[27]) begin
			m    = r_s2[27:1];
			m[0] = r_s2[1] | r_s2[0];
			e9   = {1'b0, e_s2} + 9'd1;
		end else begin
			sh   = ({3'b000, lz_s2} < en_e) ? {3'b000, lz_s2} : en_e;
			m    = r_s2[26:0] << sh;
			e9   = {1'b0, e_s2 - sh};
		end
		rnd = m[2] & (m[1] | m[0] | m[3]);
		p   = {e9 - 9'd1, 23'd0} + {8'd0, m[26:3]} + {31'd0, rnd};
		if (spec_s2) begin
			res = sval_s2;
		end else if (r_s2 == 28'd0) begin
			res = {zsg_s2, 31'd0};
		end else if (p[30:23] == EXP_MAX) begin
			res = {sign_s2, POS_INF[30:0]};
		end else begin
			res = {sign_s2, p[30:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3 <= res;
		end
	end

	assign y = y_s3;
endmodule

// ===== rtl/swnp_div_lane.sv =====
// ----------------------------------------------------------------------------
// swnp_div_lane: pipelined float32 divider lane
// Normalizes both operands, produces one quotient bit per stage by restoring
// division and rounds to nearest even, with gradual underflow.
// ----------------------------------------------------------------------------
module swnp_div_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] w,
	input  logic [31:0] s,
	output logic [31:0] q
);
	import swnp_pkg::*;

	logic [23:0]       mw_s1, ms_s1;
	logic signed [9:0] ew_s1, es_s1;
	logic              sg_s1, spec_s1;
	logic [31:0]       sval_s1;

	swnp_div_t it_s [0:QUO_BITS];
	logic [31:0] res_s3;

	logic        wn, sn, wi, si, wz, sz, sg;
	logic [31:0] sval;
	logic [23:0] mwr, msr, mwn, msn;
	logic [4:0]  lzw, lzs;

	always_comb begin
		wn  = is_nan(w);
		sn  = is_nan(s);
		wi  = is_inf(w);
		si  = is_inf(s);
		wz  = w[30:0] == 31'd0;
		sz  = s[30:0] == 31'd0;
		sg  = w[31] ^ s[31];
		mwr = {w[30:23] != 8'd0, w[22:0]};
		msr = {s[30:23] != 8'd0, s[22:0]};
		lzw = 5'd0;
		lzs = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (mwr[i]) begin
				lzw = 5'(23 - i);
			end
			if (msr[i]) begin
				lzs = 5'(23 - i);
			end
		end
		mwn = mwr << lzw;
		msn = msr << lzs;
		if (wn) begin
			sval = w | QUIET_BIT;
		end else if (sn) begin
			sval = s | QUIET_BIT;
		end else if ((wi && si) || (wz && sz)) begin
			sval = QNAN_DEFAULT;
		end else if (wi || sz) begin
			sval = {sg, POS_INF[30:0]};
		end else begin
			sval = {sg, 31'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mw_s1   <= mwn;
			ms_s1   <= msn;
			ew_s1   <= $signed({2'b00, (w[30:23] == 8'd0) ? 8'd1 : w[30:23]})
				- $signed({5'd0, lzw});
			es_s1   <= $signed({2'b00, (s[30:23] == 8'd0) ? 8'd1 : s[30:23]})
				- $signed({5'd0, lzs});
			sg_s1   <= sg;
			spec_s1 <= wn | sn | wi | si | wz | sz;
			sval_s1 <= sval;
		end
	end

	logic lt;

	always_comb begin
		lt = mw_s1 < ms_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s[0].rem  <= lt ? {mw_s1, 1'b0} : {1'b0, mw_s1};
			it_s[0].quo  <= '0;
			it_s[0].dsr  <= ms_s1;
			it_s[0].ex   <= ew_s1 - es_s1 + (lt ? 10'sd126 : 10'sd127);
			it_s[0].sg   <= sg_s1;
			it_s[0].spec <= spec_s1;
			it_s[0].sval <= sval_s1;
		end
	end

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_iter
		logic                ge;
		logic [QUO_BITS-1:0] nrem;

		always_comb begin
			ge   = it_s[k].rem >= {1'b0, it_s[k].dsr};
			nrem = ge ? it_s[k].rem - {1'b0, it_s[k].dsr} : it_s[k].rem;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k+1].rem  <= {nrem[QUO_BITS-2:0], 1'b0};
				it_s[k+1].quo  <= {it_s[k].quo[QUO_BITS-2:0], ge};
				it_s[k+1].dsr  <= it_s[k].dsr;
				it_s[k+1].ex   <= it_s[k].ex;
				it_s[k+1].sg   <= it_s[k].sg;
				it_s[k+1].spec <= it_s[k].spec;
				it_s[k+1].sval <= it_s[k].sval;
			end
		end
	end

	swnp_div_t           fin;
	logic                st, rnd, ovf;
	logic [9:0]          shv;
	logic [QUO_BITS-1:0] qs;
	logic [8:0]          eu;
	logic [31:0]         p, res;

	always_comb begin
		fin = it_s[QUO_BITS];
		st  = fin.rem != '0;
		ovf = fin.ex > 10'sd254;
		shv = 10'd0;
		if (fin.ex >= 10'sd1) begin
			qs = fin.quo;
			eu = fin.ex[8:0];
		end else begin
			shv = 10'(10'sd1 - fin.ex);
			eu  = 9'd1;
			if (shv >= 10'(QUO_BITS + 1)) begin
				qs = '0;
				st = 1'b1;
			end else begin
				qs = fin.quo >> shv;
				st = st | (|(fin.quo & ~({QUO_BITS{1'b1}} << shv)));
			end
		end
		rnd = qs[0] & (st | qs[1]);
		p   = {eu - 9'd1, 23'd0} + {8'd0, qs[QUO_BITS-1:1]} + {31'd0, rnd};
		if (fin.spec) begin
			res = fin.sval;
		end else if (ovf || (p[30:23] == EXP_MAX)) begin
			res = {fin.sg, POS_INF[30:0]};
		end else begin
			res = {fin.sg, p[30:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res;
		end
	end

	assign q = res_s3;
endmodule

// ===== rtl/skin_weight_normalize_pack.sv =====
// ----------------------------------------------------------------------------
// skin_weight_normalize_pack: bone weight normalizer and half packer
// Sums four float32 weights, divides each by the sum in four parallel lanes
// and packs the results as truncated halves next to the float32 results.
//
// Usage: vtx_in takes one vertex word (position, four weights, four bone
// indices) per handshake; vtx_out gives one result word per vertex, in
// order. The weight sum runs through three chained float adders, then four
// divider lanes, then the output register. One word is accepted every
// cycle while vtx_in.ready is high; the rate is set by the fully pipelined
// adders and lanes. A skid register behind the output register absorbs one
// word when the receiver stalls; the pipeline then holds and vtx_in.ready
// drops until the skid word has moved on. Reset clears all valid flags, so
// no word is in flight and the block is ready right after reset is
// released.
// ----------------------------------------------------------------------------
module skin_weight_normalize_pack (
	input logic   clk,
	input logic   arst_n,
	swnp_if.sink   vtx_in,
	swnp_if.source vtx_out
);
	import swnp_pkg::*;

	localparam int SUM_LAT  = 9;
	localparam int PIPE_LAT = 37;

	logic     en;
	logic     ov_q, skv_q;
	logic     v_q [1:PIPE_LAT];
	swnp_in_t sd_q [1:PIPE_LAT];

	logic [31:0] sum1, sum2, sum3, dsr;
	logic [31:0] nw [0:3];

	assign en           = !skv_q;
	assign vtx_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_LAT; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_q[1] <= vtx_in.valid;
			for (int i = 2; i <= PIPE_LAT; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[1] <= vtx_in.data;
			for (int i = 2; i <= PIPE_LAT; i++) begin
				sd_q[i] <= sd_q[i-1];
			end
		end
	end

	swnp_fadd u_add0 (
		.clk (clk), .en (en),
		.a   (vtx_in.data.weight_0), .b (vtx_in.data.weight_1), .y (sum1)
	);

	swnp_fadd u_add1 (
		.clk (clk), .en (en), .a (sum1), .b (sd_q[3].weight_2), .y (sum2)
	);

	swnp_fadd u_add2 (
		.clk (clk), .en (en), .a (sum2), .b (sd_q[6].weight_3), .y (sum3)
	);

	// A sum that is zero or negative divides by one; a NaN sum stays.
	assign dsr = ((sum3[30:0] == 31'd0) || (sum3[31] && !is_nan(sum3))) ? ONE_F : sum3;

	swnp_div_lane u_lane0 (
		.clk (clk), .en (en), .w (sd_q[SUM_LAT].weight_0), .s (dsr), .q (nw[0])
	);
	swnp_div_lane u_lane1 (
		.clk (clk), .en (en), .w (sd_q[SUM_LAT].weight_1), .s (dsr), .q (nw[1])
	);
	swnp_div_lane u_lane2 (
		.clk (clk), .en (en), .w (sd_q[SUM_LAT].weight_2), .s (dsr), .q (nw[2])
	);
	swnp_div_lane u_lane3 (
		.clk (clk), .en (en), .w (sd_q[SUM_LAT].weight_3), .s (dsr), .q (nw[3])
	);

	swnp_out_t mrg;

	always_comb begin
		mrg.out_pos_x     = sd_q[PIPE_LAT].pos_x;
		mrg.out_pos_y     = sd_q[PIPE_LAT].pos_y;
		mrg.out_pos_z     = sd_q[PIPE_LAT].pos_z;
		mrg.bone_ids_out  = sd_q[PIPE_LAT].bone_ids_in;
		mrg.norm_weight_0 = nw[0];
		mrg.norm_weight_1 = nw[1];
		mrg.norm_weight_2 = nw[2];
		mrg.norm_weight_3 = nw[3];
		mrg.half_weights  = {half_trunc(nw[3]), half_trunc(nw[2]),
			half_trunc(nw[1]), half_trunc(nw[0])};
	end

	swnp_out_t od_q, skd_q;
	logic      push;

	assign push = en && v_q[PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			skv_q <= 1'b0;
		end else if (push) begin
			if (ov_q && !vtx_out.ready) begin
				skv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end else if (skv_q && (!ov_q || vtx_out.ready)) begin
			ov_q  <= 1'b1;
			skv_q <= 1'b0;
		end else if (vtx_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (ov_q && !vtx_out.ready) begin
				skd_q <= mrg;
			end else begin
				od_q <= mrg;
			end
		end else if (skv_q && (!ov_q || vtx_out.ready)) begin
			od_q <= skd_q;
		end
	end

	assign vtx_out.valid = ov_q;
	assign vtx_out.data  = od_q;
endmodule
